@@ rtl/csc_pkg.sv @@
// Shared constants and types for the clock (second chance) replacement core.
// No dependencies; imported by clock_second_chance_replacement_core.
`timescale 1ns / 1ps
`default_nettype none

package csc_pkg;

  // Default build sizes
  localparam int unsigned CSC_FRAMES    = 8;
  localparam int unsigned CSC_PAGE_BITS = 16;

  // Register file
  localparam int unsigned CFG_W         = 4;
  localparam logic [CFG_W-1:0] CFG_FRAMES_RESET = 4'd5;
  localparam int unsigned APB_AW        = 3;
  localparam int unsigned APB_DW        = 32;
  localparam logic        REG_FRAMES_IN_USE = 1'b0;

  // Result fields of fixed width
  localparam int unsigned CNT_W         = 16;
  localparam int unsigned OUT_FRAME_W   = 3;

  // Outcome of one page request
  typedef enum logic [1:0] {
    RES_HIT,
    RES_FILL,
    RES_REPL
  } res_kind_e;

endpackage

`default_nettype wire

@@ rtl/clock_second_chance_replacement_core.sv @@
// Clock (second chance) page replacement core: frame store, reference bits,
// hand and a small sequencer around one ring-step/compare unit. Uses csc_pkg.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid_i, in_stall_o, page_number_i,    | request in
//          | last_reference_i                          |
//  out     | out_valid_o, out_stall_i, hit_o, ...      | result out
//  cfg     | psel, penable, pwrite, paddr, pwdata, ... | APB slave
//
// Per request: a fill into an empty ring goes straight to the result; otherwise
// the filled frames are searched for the page. With a full ring of n frames the
// hand is first reduced modulo n by repeated subtraction, then the ring is
// searched and, on a miss, the reference bits are swept. The frame store read
// port sets the pace: one frame looked at per cycle.
// Reset empties all frames, clears the count and sets frames_in_use to 5.
// A result waiting on out_stall_i holds the next request in its last step.
`timescale 1ns / 1ps
`default_nettype none

module clock_second_chance_replacement_core
  import csc_pkg::*;
#(
  parameter int unsigned FRAMES    = CSC_FRAMES,
  parameter int unsigned PAGE_BITS = CSC_PAGE_BITS
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // request channel
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic [PAGE_BITS-1:0]   page_number_i,
  input  wire logic                   last_reference_i,
  // result channel
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic                        hit_o,
  output logic                        filled_free_frame_o,
  output logic                        replaced_o,
  output logic [OUT_FRAME_W-1:0]      frame_index_o,
  output logic [PAGE_BITS-1:0]        evicted_page_o,
  output logic [CNT_W-1:0]            replacement_count_o,
  // configuration port
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [APB_AW-1:0]      paddr,
  input  wire logic [APB_DW-1:0]      pwdata,
  output logic [APB_DW-1:0]           prdata,
  output logic                        pready
);

  localparam int unsigned IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned CW = $clog2(FRAMES + 1);
  localparam int unsigned NW = (CW > CFG_W) ? CW : CFG_W;
  localparam int unsigned XW = IW + OUT_FRAME_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_SEARCH,
    ST_SWEEP,
    ST_RESULT
  } state_e;

  state_e               state_q;
  logic [CFG_W-1:0]     cfg_q;
  logic [PAGE_BITS-1:0] page_q;
  logic                 last_q;
  logic [CW-1:0]        n_q;
  logic                 full_q;
  logic [IW-1:0]        pos_q;
  logic [IW-1:0]        hmod_q;
  logic [CW-1:0]        rem_q;
  logic [IW-1:0]        cmp_pos_q;
  logic                 cmp_vld_q;
  logic [CW-1:0]        filled_q;
  logic [IW-1:0]        hand_q;
  logic [FRAMES-1:0]    ref_q;
  logic [CNT_W-1:0]     cnt_q;
  res_kind_e            kind_q;
  logic [IW-1:0]        res_frame_q;

  logic                 out_valid_q;
  logic                 out_hit_q;
  logic                 out_fill_q;
  logic                 out_repl_q;
  logic [OUT_FRAME_W-1:0] out_frame_q;
  logic [PAGE_BITS-1:0] out_evict_q;
  logic [CNT_W-1:0]     out_cnt_q;

  // frame store
  logic [PAGE_BITS-1:0] mem [FRAMES];
  logic [PAGE_BITS-1:0] mem_rd_q;

  logic [CW-1:0]        n_eff;
  logic [NW-1:0]        cfg_ext;
  logic                 in_acc;
  logic                 cfg_we;
  logic                 match;
  logic                 out_ready;
  logic                 mem_we;
  logic [CNT_W-1:0]     cnt_inc;
  logic [XW-1:0]        frame_ext;

  // one step round the ring of n frames
  function automatic logic [IW-1:0] ring_inc(input logic [IW-1:0] p,
                                             input logic [CW-1:0] n);
    logic [CW-1:0] nxt;
    nxt = CW'(p) + CW'(1);
    return (nxt == n) ? '0 : nxt[IW-1:0];
  endfunction

  // effective frame count: 0 acts as 1, above the build acts as FRAMES
  always_comb begin
    cfg_ext = NW'(cfg_q);
    if (cfg_q == '0) begin
      n_eff = CW'(1);
    end else if (cfg_ext > NW'(FRAMES)) begin
      n_eff = CW'(FRAMES);
    end else begin
      n_eff = cfg_ext[CW-1:0];
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && (state_q == ST_IDLE);
  assign match      = cmp_vld_q && (mem_rd_q == page_q);
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign mem_we     = (state_q == ST_RESULT) && out_ready && (kind_q != RES_HIT);
  assign cnt_inc    = (cnt_q == '1) ? cnt_q : cnt_q + CNT_W'(1);
  assign frame_ext  = XW'(res_frame_q);

  // APB register access
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[APB_AW-1] == REG_FRAMES_IN_USE);
  assign prdata = (paddr[APB_AW-1] == REG_FRAMES_IN_USE) ? APB_DW'(cfg_q) : '0;

  // frame store: one write, one registered read at the ring position
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[res_frame_q] <= page_q;
    end
    mem_rd_q <= mem[pos_q];
  end

  // sequencer, policy state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cfg_q       <= CFG_FRAMES_RESET;
      page_q      <= '0;
      last_q      <= 1'b0;
      n_q         <= '0;
      full_q      <= 1'b0;
      pos_q       <= '0;
      hmod_q      <= '0;
      rem_q       <= '0;
      cmp_pos_q   <= '0;
      cmp_vld_q   <= 1'b0;
      filled_q    <= '0;
      hand_q      <= '0;
      ref_q       <= '0;
      cnt_q       <= '0;
      kind_q      <= RES_HIT;
      res_frame_q <= '0;
      out_valid_q <= 1'b0;
      out_hit_q   <= 1'b0;
      out_fill_q  <= 1'b0;
      out_repl_q  <= 1'b0;
      out_frame_q <= '0;
      out_evict_q <= '0;
      out_cnt_q   <= '0;
    end else begin
      if (cfg_we) begin
        cfg_q <= pwdata[CFG_W-1:0];
      end

      // compare pipeline is registered alongside the store read, so it lines up with mem_rd_q
      cmp_pos_q <= pos_q;
      cmp_vld_q <= (state_q == ST_SEARCH) && (rem_q != '0) && !match;

      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            page_q <= page_number_i;
            last_q <= last_reference_i;
            n_q    <= n_eff;
            if (filled_q < n_eff) begin
              full_q <= 1'b0;
              if (filled_q == '0) begin
                kind_q      <= RES_FILL;
                res_frame_q <= '0;
                state_q     <= ST_RESULT;
              end else begin
                pos_q   <= '0;
                rem_q   <= filled_q;
                state_q <= ST_SEARCH;
              end
            end else begin
              full_q  <= 1'b1;
              pos_q   <= hand_q;
              state_q <= ST_MOD;
            end
          end
        end

        // hand modulo n by repeated subtraction
        ST_MOD: begin
          if (CW'(pos_q) >= n_q) begin
            pos_q <= IW'(CW'(pos_q) - n_q);
          end else begin
            hmod_q  <= pos_q;
            rem_q   <= n_q;
            state_q <= ST_SEARCH;
          end
        end

        // look for the page, one frame a cycle
        ST_SEARCH: begin
          if (match) begin
            kind_q      <= RES_HIT;
            res_frame_q <= cmp_pos_q;
            state_q     <= ST_RESULT;
          end else if (rem_q != '0) begin
            pos_q <= ring_inc(pos_q, n_q);
            rem_q <= rem_q - CW'(1);
          end else if (!cmp_vld_q) begin
            if (full_q) begin
              pos_q   <= ring_inc(hmod_q, n_q);
              state_q <= ST_SWEEP;
            end else begin
              kind_q      <= RES_FILL;
              res_frame_q <= filled_q[IW-1:0];
              state_q     <= ST_RESULT;
            end
          end
        end

        // second chance: clear set bits until a clear one turns up
        ST_SWEEP: begin
          if (!ref_q[pos_q]) begin
            kind_q      <= RES_REPL;
            res_frame_q <= pos_q;
            state_q     <= ST_RESULT;
          end else begin
            ref_q[pos_q] <= 1'b0;
            pos_q        <= ring_inc(pos_q, n_q);
          end
        end

        // commit policy state and hand the result over
        ST_RESULT: begin
          if (out_ready) begin
            out_valid_q <= 1'b1;
            out_hit_q   <= (kind_q == RES_HIT);
            out_fill_q  <= (kind_q == RES_FILL);
            out_repl_q  <= (kind_q == RES_REPL);
            out_frame_q <= frame_ext[OUT_FRAME_W-1:0];
            out_evict_q <= (kind_q == RES_REPL) ? mem_rd_q : '0;
            out_cnt_q   <= (kind_q == RES_REPL) ? cnt_inc : cnt_q;
            hand_q      <= res_frame_q;
            case (kind_q)
              RES_HIT:  ref_q[res_frame_q] <= 1'b1;
              RES_FILL: begin
                ref_q[res_frame_q] <= 1'b0;
                filled_q           <= filled_q + CW'(1);
              end
              RES_REPL: begin
                ref_q[res_frame_q] <= 1'b0;
                cnt_q              <= cnt_inc;
              end
              default: ;
            endcase
            // end of string empties the ring afterwards
            if (last_q) begin
              ref_q    <= '0;
              filled_q <= '0;
              hand_q   <= '0;
              cnt_q    <= '0;
            end
            state_q <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o         = out_valid_q;
  assign hit_o               = out_hit_q;
  assign filled_free_frame_o = out_fill_q;
  assign replaced_o          = out_repl_q;
  assign frame_index_o       = out_frame_q;
  assign evicted_page_o      = out_evict_q;
  assign replacement_count_o = out_cnt_q;

`ifndef NO_ASSERTIONS
  a_filled_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CW'(FRAMES) >= filled_q)
    else $error("frames_filled beyond frame count");

  a_hand_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    IW'(FRAMES - 1) >= hand_q)
    else $error("clock hand beyond frame count");

  a_one_outcome: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot({hit_o, filled_free_frame_o, replaced_o}))
    else $error("result must be exactly one of hit, fill, replacement");

  a_evict_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !replaced_o) |-> (evicted_page_o == '0))
    else $error("evicted page set without a replacement");

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && replaced_o) |-> (replacement_count_o != '0))
    else $error("replacement count zero on a replacement");
`endif

endmodule

`default_nettype wire
